FILE: design/vector4_cosine_similarity_core_defines.svh
// Assertion macros shared by the cosine similarity core.
`ifndef VECTOR4_COSINE_SIMILARITY_CORE_DEFINES_SVH
`define VECTOR4_COSINE_SIMILARITY_CORE_DEFINES_SVH

// Check that holds while reset is released.
`define VCS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that holds in the cycle after a condition.
`define VCS_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: design/vcs_pkg.sv
`default_nettype none
package vcs_pkg;
    localparam int COMP_W_DEF = 16;
    localparam int COS_W      = 16;
    localparam int FRAC_BITS  = 14;
    localparam int ONE_Q14    = 1 << FRAC_BITS;
    localparam int LANES      = 4;
    localparam int QBITS      = FRAC_BITS + 2;
endpackage
`default_nettype wire

FILE: design/vector4_cosine_similarity_core.sv
`default_nettype none
// Cosine of the angle between two 4-component vectors, in signed Q2.14.
// Takes one transfer per clock unless m_tready stalls it, and is fully
// pipelined through the lanes, the merge, the product of squared magnitudes,
// the square root (one bit per stage), the divider (one quotient bit per
// stage) and the output register. A stall on m_tready
// freezes the whole pipeline; s_tready stays high while the output slot is
// empty or being taken. A zero vector gives cosine 0 with zero_length set.
module vector4_cosine_similarity_core import vcs_pkg::*; #(
    parameter int COMPONENT_WIDTH = COMP_W_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w
    input  wire logic [8*COMPONENT_WIDTH-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // cosine [15:0], zero_length [16], zero pad
    output logic [23:0]                         m_tdata
);
    `include "vector4_cosine_similarity_core_defines.svh"

    localparam int CW   = COMPONENT_WIDTH;
    localparam int SQW  = 2*CW + 2;            // squared magnitude width
    localparam int PW   = 2*SQW;               // product, even
    localparam int RW   = PW/2;                // root width
    localparam int LAT  = 3 + RW + (QBITS-1) + 1;

    logic en;
    logic [LAT-1:0] vld_reg;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en)  vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
    end

    logic [LANES*2*CW-1:0] ab, aa, bb;
    logic [LANES-1:0]      ab_neg;
    for (genvar i = 0; i < LANES; i++) begin : g_lane
        vcs_lane #(.COMP_W(CW)) u_lane (
            .aclk(aclk), .en(en),
            .a(s_tdata[i*CW +: CW]), .b(s_tdata[(i+LANES)*CW +: CW]),
            .ab_reg(ab[i*2*CW +: 2*CW]), .ab_neg_reg(ab_neg[i]),
            .aa_reg(aa[i*2*CW +: 2*CW]), .bb_reg(bb[i*2*CW +: 2*CW])
        );
    end

    logic [SQW:0]   dot;
    logic [SQW-1:0] sa, sb;
    vcs_merge #(.COMP_W(CW)) u_merge (
        .aclk(aclk), .en(en), .ab(ab), .ab_neg(ab_neg), .aa(aa), .bb(bb),
        .dot_reg(dot), .sa_reg(sa), .sb_reg(sb)
    );

    // product of squared magnitudes plus side data for the sqrt pipe
    logic [PW-1:0]  prod_reg;
    logic [SQW+1:0] side_reg;  // {zero, neg, |dot|}
    logic [SQW-1:0] dmag;
    assign dmag = dot[SQW] ? SQW'(~dot + 1'b1) : dot[SQW-1:0];
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= PW'(sa) * PW'(sb);
            side_reg <= {(sa == '0) || (sb == '0), dot[SQW], dmag};
        end
    end

    logic [RW-1:0]  root;
    logic [SQW+1:0] side_s;
    vcs_pipe_sqrt #(.NW(PW), .SW(SQW+2)) u_sqrt (
        .aclk(aclk), .en(en), .n(prod_reg), .side(side_reg),
        .root(root), .side_out(side_s)
    );

    logic [RW-1:0]    den;
    logic [QBITS-1:0] q;
    logic [1:0]       fl;
    assign den = (side_s[SQW+1]) ? RW'(1) : root;
    vcs_pipe_div #(.DW(RW)) u_div (
        .aclk(aclk), .en(en),
        .num(side_s[SQW+1] ? RW'(0) : RW'(side_s[SQW-1:0])),
        .den(den), .flags(side_s[SQW+1:SQW]),
        .q(q), .flags_out(fl)
    );

    logic [QBITS-1:0] qc;
    logic [COS_W-1:0] cos_reg;
    logic             zl_reg;
    assign qc = (q > QBITS'(ONE_Q14)) ? QBITS'(ONE_Q14) : q;
    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= fl[0] ? COS_W'(~qc + 1'b1) : COS_W'(qc);
            zl_reg  <= fl[1];
        end
    end
    assign m_tdata = {7'b0, zl_reg, cos_reg};

    logic cos_ok;
    logic m_stall;
    assign cos_ok  = ($signed(cos_reg) <= ONE_Q14) && ($signed(cos_reg) >= -ONE_Q14);
    assign m_stall = m_tvalid && !m_tready;

    `VCS_ASSERT(a_cos_range, !m_tvalid || cos_ok, "cosine out of range")
    `VCS_ASSERT(a_zero_cos, !(m_tvalid && zl_reg) || cos_reg == '0, "zero vector, nonzero cosine")
    `VCS_ASSERT_NEXT(a_hold, m_stall, m_tvalid && $stable(m_tdata), "stalled result changed")
endmodule
`default_nettype wire

FILE: design/vcs_lane.sv
`default_nettype none
// One component lane: magnitudes, the product a*b with its sign, and two squares.
module vcs_lane import vcs_pkg::*; #(
    parameter int COMP_W = COMP_W_DEF
) (
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic [COMP_W-1:0] a,
    input  wire logic [COMP_W-1:0] b,
    output logic [2*COMP_W-1:0]    ab_reg,
    output logic                   ab_neg_reg,
    output logic [2*COMP_W-1:0]    aa_reg,
    output logic [2*COMP_W-1:0]    bb_reg
);
    logic [COMP_W-1:0] ma, mb;
    assign ma = a[COMP_W-1] ? (~a + 1'b1) : a;
    assign mb = b[COMP_W-1] ? (~b + 1'b1) : b;

    always_ff @(posedge aclk) begin
        if (en) begin
            ab_reg     <= (2*COMP_W)'(ma) * (2*COMP_W)'(mb);
            ab_neg_reg <= a[COMP_W-1] ^ b[COMP_W-1];
            aa_reg     <= (2*COMP_W)'(ma) * (2*COMP_W)'(ma);
            bb_reg     <= (2*COMP_W)'(mb) * (2*COMP_W)'(mb);
        end
    end
endmodule
`default_nettype wire

FILE: design/vcs_merge.sv
`default_nettype none
// Merges lane products: signed dot product and squared magnitudes.
module vcs_merge import vcs_pkg::*; #(
    parameter int COMP_W = COMP_W_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    en,
    input  wire logic [LANES*2*COMP_W-1:0] ab,
    input  wire logic [LANES-1:0]        ab_neg,
    input  wire logic [LANES*2*COMP_W-1:0] aa,
    input  wire logic [LANES*2*COMP_W-1:0] bb,
    output logic [2*COMP_W+2:0]          dot_reg,  // signed
    output logic [2*COMP_W+1:0]          sa_reg,
    output logic [2*COMP_W+1:0]          sb_reg
);
    localparam int SW = 2*COMP_W + 2;
    logic [SW:0]   dsum;
    logic [SW-1:0] asum, bsum;

    always_comb begin
        dsum = '0;
        asum = '0;
        bsum = '0;
        for (int i = 0; i < LANES; i++) begin
            if (ab_neg[i]) dsum = dsum - (SW+1)'(ab[i*2*COMP_W +: 2*COMP_W]);
            else           dsum = dsum + (SW+1)'(ab[i*2*COMP_W +: 2*COMP_W]);
            asum = asum + SW'(aa[i*2*COMP_W +: 2*COMP_W]);
            bsum = bsum + SW'(bb[i*2*COMP_W +: 2*COMP_W]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dot_reg <= dsum;
            sa_reg  <= asum;
            sb_reg  <= bsum;
        end
    end
endmodule
`default_nettype wire

FILE: design/vcs_pipe_sqrt.sv
`default_nettype none
// Pipelined restoring square root, one result bit per stage.
module vcs_pipe_sqrt import vcs_pkg::*; #(
    parameter int NW = 64,
    parameter int SW = 32
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [NW-1:0] n,
    input  wire logic [SW-1:0] side,
    output logic [NW/2-1:0]    root,
    output logic [SW-1:0]      side_out
);
    localparam int RW = NW/2;
    logic [NW-1:0] rem_reg  [1:RW];
    logic [RW-1:0] res_reg  [1:RW];
    logic [SW-1:0] side_reg [1:RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [RW+1:0]   trial;
        logic [RW+1:0]   part;
        logic [RW-1:0]   rn;
        logic [NW-1:0]   remn;
        logic [NW-1:0]   rem_cur;
        logic [RW-1:0]   res_cur;
        logic [SW-1:0]   side_cur;
        localparam int SH = 2*(RW-1-k);
        if (k == 0) begin : g_first
            assign rem_cur  = n;
            assign res_cur  = '0;
            assign side_cur = side;
        end else begin : g_next
            assign rem_cur  = rem_reg[k];
            assign res_cur  = res_reg[k];
            assign side_cur = side_reg[k];
        end
        always_comb begin
            part  = (RW+2)'(rem_cur >> SH);
            trial = {res_cur, 2'b01};
            rn    = res_cur << 1;
            remn  = rem_cur;
            if (part >= trial) begin
                rn   = rn | RW'(1);
                remn = rem_cur - (NW'(trial) << SH);
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]  <= remn;
                res_reg[k+1]  <= rn;
                side_reg[k+1] <= side_cur;
            end
        end
    end

    assign root     = res_reg[RW];
    assign side_out = side_reg[RW];
endmodule
`default_nettype wire

FILE: design/vcs_pipe_div.sv
`default_nettype none
// Pipelined fractional divider: q = floor(ONE * num / den), num <= den.
module vcs_pipe_div import vcs_pkg::*; #(
    parameter int DW = 34
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [DW-1:0] num,
    input  wire logic [DW-1:0] den,
    input  wire logic [1:0]    flags,   // {zero_length, negative}
    output logic [QBITS-1:0]   q,
    output logic [1:0]         flags_out
);
    localparam int ST = QBITS - 1;  // integer bit plus fraction bits
    logic [DW:0]      rem_reg  [1:ST];
    logic [DW-1:0]    den_reg  [1:ST];
    logic [QBITS-1:0] q_reg    [1:ST];
    logic [1:0]       f_reg    [1:ST];

    for (genvar k = 0; k < ST; k++) begin : g_stage
        logic [DW:0]      r;
        logic [QBITS-1:0] qn;
        logic [DW:0]      rem_cur;
        logic [DW-1:0]    den_cur;
        logic [QBITS-1:0] q_cur;
        logic [1:0]       f_cur;
        if (k == 0) begin : g_first
            assign rem_cur = {1'b0, num};
            assign den_cur = den;
            assign q_cur   = '0;
            assign f_cur   = flags;
        end else begin : g_next
            assign rem_cur = rem_reg[k];
            assign den_cur = den_reg[k];
            assign q_cur   = q_reg[k];
            assign f_cur   = f_reg[k];
        end
        always_comb begin
            r  = rem_cur;
            qn = q_cur << 1;
            if (r >= {1'b0, den_cur}) begin
                r  = r - {1'b0, den_cur};
                qn = qn | QBITS'(1);
            end
            if (k < ST - 1) r = r << 1;
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= r;
                den_reg[k+1] <= den_cur;
                q_reg[k+1]   <= qn;
                f_reg[k+1]   <= f_cur;
            end
        end
    end

    assign q         = q_reg[ST];
    assign flags_out = f_reg[ST];
endmodule
`default_nettype wire

FILE: tb/cosine_scoreboard.sv
`timescale 1ns / 1ps
module cosine_scoreboard import vcs_pkg::*; (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    input  wire logic           s_tready,
    input  wire logic [127:0]   s_tdata,
    input  wire logic           m_tvalid,
    input  wire logic           m_tready,
    input  wire logic [23:0]    m_tdata,
    output int                  mismatches,
    output int                  pending,
    output int                  results_seen,
    output int                  zero_results
);
    typedef struct packed {
        logic        zero_length;
        logic [15:0] cosine;
    } cos_result_t;

    cos_result_t expected_cosines[$];

    // exact integer cosine: 16384 * dot / floor(sqrt(|a|^2 |b|^2)), toward zero
    function automatic cos_result_t predict_cosine(logic [127:0] vecs);
        logic signed [35:0] ea, eb, dot;
        logic [35:0]        sa, sb, dmag, root, trial;
        logic [71:0]        prod, q;
        cos_result_t        res;
        dot = '0;
        sa = '0;
        sb = '0;
        for (int i = 0; i < LANES; i++) begin
            ea = $signed(vecs[16*i +: 16]);
            eb = $signed(vecs[16*(i+4) +: 16]);
            dot = dot + ea * eb;
            sa = sa + 36'(ea * ea);
            sb = sb + 36'(eb * eb);
        end
        if (sa == 0 || sb == 0) begin
            res.zero_length = 1'b1;
            res.cosine = '0;
            return res;
        end
        prod = 72'(sa) * 72'(sb);
        root = '0;
        for (int k = 35; k >= 0; k--) begin
            trial = root | (36'd1 << k);
            if (72'(trial) * 72'(trial) <= prod)
                root = trial;
        end
        dmag = (dot < 0) ? 36'(-dot) : 36'(dot);
        q = (72'(dmag) << FRAC_BITS) / 72'(root);
        if (q > ONE_Q14)
            q = ONE_Q14;
        res.zero_length = 1'b0;
        res.cosine = (dot < 0) ? 16'(-q[15:0]) : q[15:0];
        return res;
    endfunction

    assign pending = expected_cosines.size();

    always @(posedge aclk) begin
        cos_result_t got, want;
        if (!aresetn) begin
            mismatches <= 0;
            results_seen <= 0;
            zero_results <= 0;
            expected_cosines.delete();
        end else begin
            if (s_tvalid && s_tready)
                expected_cosines.push_back(predict_cosine(s_tdata));
            if (m_tvalid && m_tready) begin
                got.cosine = m_tdata[15:0];
                got.zero_length = m_tdata[16];
                results_seen <= results_seen + 1;
                if (got.zero_length)
                    zero_results <= zero_results + 1;
                if (expected_cosines.size() == 0) begin
                    if (mismatches < 10)
                        $display("[%0t] unexpected result cosine=%0d zero_length=%0b",
                                 $realtime, $signed(got.cosine), got.zero_length);
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_cosines.pop_front();
                    if (got.cosine !== want.cosine || got.zero_length !== want.zero_length
                            || m_tdata[23:17] !== '0) begin
                        if (mismatches < 10)
                            $display("[%0t] mismatch: cosine exp %0d got %0d, zero_length exp %0b got %0b, pad %h",
                                     $realtime, $signed(want.cosine), $signed(got.cosine),
                                     want.zero_length, got.zero_length, m_tdata[23:17]);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: tb/tb_vector4_cosine_similarity_core.sv
`timescale 1ns / 1ps
module tb_vector4_cosine_similarity_core;
    import vcs_pkg::*;

    localparam int RANDOM_ITEMS = 1750;
    localparam int LONG_HOLD    = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 80;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [23:0]  m_tdata;

    int  mismatches, pending, results_seen, zero_results;
    int  sent = 0;
    bit  hold_output = 1'b0;
    bit  sender_gaps = 1'b1;
    bit  receiver_gaps = 1'b1;

    always #5 aclk = ~aclk;

    vector4_cosine_similarity_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    cosine_scoreboard scoreboard (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .mismatches(mismatches), .pending(pending),
        .results_seen(results_seen), .zero_results(zero_results)
    );

    function automatic logic [127:0] pack_pair(logic signed [15:0] a[4], logic signed [15:0] b[4]);
        logic [127:0] d;
        for (int i = 0; i < 4; i++) begin
            d[16*i +: 16] = a[i];
            d[16*(i+4) +: 16] = b[i];
        end
        return d;
    endfunction

    function automatic logic [127:0] pair_of(int ax, int ay, int az, int aw,
                                             int bx, int by, int bz, int bw);
        logic signed [15:0] a[4], b[4];
        a = '{16'(ax), 16'(ay), 16'(az), 16'(aw)};
        b = '{16'(bx), 16'(by), 16'(bz), 16'(bw)};
        return pack_pair(a, b);
    endfunction

    // random pair of a chosen flavor, weighted toward interesting geometry
    function automatic logic [127:0] random_pair();
        logic signed [15:0] a[4], b[4];
        int flavor, k, m;
        flavor = $urandom_range(0, 9);
        for (int i = 0; i < 4; i++) begin
            a[i] = 16'($urandom);
            b[i] = 16'($urandom);
        end
        case (flavor)
            0, 1: begin
                for (int i = 0; i < 4; i++) begin
                    a[i] = 16'($signed($urandom_range(0, 14)) - 7);
                    b[i] = 16'($signed($urandom_range(0, 14)) - 7);
                end
            end
            2, 3: begin
                // b a scaled copy of a plus an offset, each component negated at random
                m = $urandom_range(0, 7);
                k = $urandom_range(1, 3);
                for (int i = 0; i < 4; i++) begin
                    a[i] = 16'($signed($urandom_range(0, 8190)) - 4095);
                    b[i] = ($urandom_range(0, 1)) ? 16'(a[i] * k + m) : 16'(-(a[i] * k) - m);
                end
            end
            4: begin
                for (int i = 0; i < 4; i++)
                    if ($urandom_range(0, 1))
                        a[i] = '0;
                if ($urandom_range(0, 3) == 0)
                    b = '{default: 16'sd0};
            end
            5: begin
                for (int i = 0; i < 4; i++) begin
                    a[i] = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
                    b[i] = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
                end
            end
            default: ;
        endcase
        return pack_pair(a, b);
    endfunction

    task automatic send_pair(logic [127:0] d);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
    endtask

    // receiver: random backpressure, with a long hold-off on request
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_output) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_output = 1'b0;
            end
            gap = receiver_gaps ? $urandom_range(0, 12) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid || hold_output));
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else if (++idle >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("** vector4_cosine_similarity_core: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners
        send_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(pair_of(0, 0, 0, 0, 5, -3, 2, 1));
        send_pair(pair_of(7, 1, -2, 9, 0, 0, 0, 0));
        send_pair(pair_of(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_pair(pair_of(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767));
        send_pair(pair_of(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_pair(pair_of(-32768, 0, 0, 0, -32768, 0, 0, 0));
        send_pair(pair_of(-32768, 0, 0, 0, 32767, 0, 0, 0));
        send_pair(pair_of(1, 0, 0, 0, 0, 1, 0, 0));
        send_pair(pair_of(0, 0, 0, 1, 0, 0, 0, -1));
        send_pair(pair_of(1, 1, 0, 0, 1, 0, 0, 0));
        send_pair(pair_of(3, 4, 0, 0, -4, 3, 0, 0));
        send_pair(pair_of(1, 2, 3, 4, 2, 4, 6, 8));
        send_pair(pair_of(1, 2, 3, 4, -1, -2, -3, -4));
        send_pair(pair_of(32767, -32768, 32767, -32768, 1, 1, 1, 1));
        send_pair(pair_of(-1, -1, -1, -1, 1, 1, 1, 1));
        send_pair(pair_of(0, 0, 0, -32768, 0, 0, 0, 0));
        send_pair(pair_of(12345, -321, 0, 77, -5, 9999, -32768, 4));
        wait_drained();

        // fill the pipeline against a stalled output
        hold_output = 1'b1;
        sender_gaps = 1'b0;
        repeat (90) send_pair(random_pair());
        sender_gaps = 1'b1;
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 250 == 0) begin
                sender_gaps = ($urandom_range(0, 2) != 0);
                receiver_gaps = ($urandom_range(0, 2) != 0);
            end
            send_pair(random_pair());
        end
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d vector pairs, checked %0d cosines (%0d zero-length), %0d mismatches",
                 sent, results_seen, zero_results, mismatches);
        $display("covered corners, parallel/antiparallel/orthogonal pairs, backpressure fill");
        if (mismatches == 0 && pending == 0)
            $display("** vector4_cosine_similarity_core: PASSED **");
        else
            $display("** vector4_cosine_similarity_core: FAILED **");
        $finish;
    end
endmodule
